@@ design/thermal_profile_hysteresis_controller_macros.svh @@
// Assertion macros shared by the heater profile controller.
`ifndef THERMAL_PROFILE_HYSTERESIS_CONTROLLER_MACROS_SVH
`define THERMAL_PROFILE_HYSTERESIS_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tphc_pkg.sv @@
// Types, constants and field helpers of the heater profile controller.
package tphc_pkg;

  // Highest temperature reading that is taken as plausible.
  localparam logic [7:0] TEMP_MAX = 8'd230;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SETPOINTS      = 3'd0;
  localparam logic [2:0] CFG_DURATIONS      = 3'd1;
  localparam logic [2:0] CFG_LOOP_COUNT     = 3'd2;
  localparam logic [2:0] CFG_BAND           = 3'd3;
  localparam logic [2:0] CFG_TICKS_PER_UNIT = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FAULT = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  typedef struct packed {
    logic               start_req;
    logic               stop_request;
    logic               sensor_fault;
    logic signed [15:0] temp_first;
    logic signed [15:0] temp_second;
  } in_item_t;

  typedef struct packed {
    logic        relay_on;
    logic        running;
    logic [7:0]  loop_number;
    logic [2:0]  segment_number;
    logic [35:0] remaining_ticks;
    logic        temp_valid;
    logic [7:0]  temperature;
    logic [1:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic [31:0] setpoints;
    logic [63:0] segment_durations;
    logic [7:0]  loop_count;
    logic [7:0]  band;
    logic [19:0] ticks_per_unit;
  } cfg_t;

  // Reading check and hysteresis decision for one tick.
  typedef struct packed {
    logic       temp_ok;
    logic [7:0] temp;
    logic       heat_on;
    logic       heat_off;
  } sense_t;

  // Duration of one segment; segments past the fourth are always empty.
  function automatic logic [15:0] seg_dur(input logic [63:0] durs, input logic [2:0] seg);
    logic [15:0] d;
    case (seg)
      3'd0:    d = durs[15:0];
      3'd1:    d = durs[31:16];
      3'd2:    d = durs[47:32];
      3'd3:    d = durs[63:48];
      default: d = 16'd0;
    endcase
    return d;
  endfunction

  // Setpoint of one segment; segments past the fourth read as zero.
  function automatic logic [7:0] seg_setpoint(input logic [31:0] sps, input logic [2:0] seg);
    logic [7:0] s;
    case (seg)
      3'd0:    s = sps[7:0];
      3'd1:    s = sps[15:8];
      3'd2:    s = sps[23:16];
      3'd3:    s = sps[31:24];
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

@@ design/tphc_sense.sv @@
// Reading selection with retry and the hysteresis band comparison.
module tphc_sense (
  input  logic signed [15:0] temp_first,
  input  logic signed [15:0] temp_second,
  input  logic [7:0]         setpoint,
  input  logic [7:0]         band,
  output tphc_pkg::sense_t   sense
);
  import tphc_pkg::*;

  logic              first_ok;
  logic              second_ok;
  logic [7:0]        temp;
  logic [6:0]        half;
  logic signed [9:0] band_lo;
  logic signed [9:0] band_hi;
  logic signed [9:0] temp_s;

  // A reading is plausible when it lies between zero and the maximum.
  assign first_ok  = !temp_first[15] && (temp_first[14:0] <= {7'd0, TEMP_MAX});
  assign second_ok = !temp_second[15] && (temp_second[14:0] <= {7'd0, TEMP_MAX});
  assign temp      = first_ok ? temp_first[7:0] : temp_second[7:0];

  // Band edges around the setpoint; half the band rounds down.
  assign half    = band[7:1];
  assign band_lo = $signed({2'b00, setpoint}) - $signed({3'b000, half});
  assign band_hi = $signed({2'b00, setpoint}) + $signed({3'b000, half});
  assign temp_s  = $signed({2'b00, temp});

  always_comb begin
    sense.temp_ok  = first_ok || second_ok;
    sense.temp     = temp;
    sense.heat_on  = temp_s < band_lo;
    sense.heat_off = temp_s > band_hi;
  end

endmodule

@@ design/tphc_core.sv @@
// Profile sequencer: run state, segment and loop stepping, relay and error.
module tphc_core #(
  parameter int NUM_SEGMENTS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  tphc_pkg::in_item_t  item,
  input  tphc_pkg::cfg_t      cfg,
  output tphc_pkg::out_item_t result
);
  import tphc_pkg::*;

  localparam int SIDX_W = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;

  // Run state.
  logic              active;
  logic [7:0]        loop_idx;
  logic [SIDX_W-1:0] seg_idx;
  logic [35:0]       ticks_left;
  logic              relay;
  logic [1:0]        last_error;

  logic              active_next;
  logic [7:0]        loop_next;
  logic [SIDX_W-1:0] seg_next;
  logic [35:0]       ticks_next;
  logic              relay_next;
  logic [1:0]        err_next;

  logic [NUM_SEGMENTS-1:0] live;
  logic                    first_ok;
  logic [SIDX_W-1:0]       first_seg;
  logic                    later_ok;
  logic [SIDX_W-1:0]       later_seg;

  logic              starting;
  logic              go;
  logic [SIDX_W-1:0] cur_seg;
  logic [7:0]        cur_loop;
  logic [8:0]        loop_inc;
  logic              at_end;
  logic [SIDX_W-1:0] mul_seg;
  logic [35:0]       prod;
  logic [35:0]       base_ticks;
  logic              tvalid;
  logic              end_run;
  sense_t            sense;

  // A segment is live when its duration in ticks is nonzero.
  always_comb begin
    for (int i = 0; i < NUM_SEGMENTS; i++) begin
      live[i] = (seg_dur(cfg.segment_durations, 3'(i)) != 16'd0) &&
                (cfg.ticks_per_unit != 20'd0);
    end
  end

  // First live segment of a loop.
  always_comb begin
    first_ok  = |live;
    first_seg = '0;
    for (int i = NUM_SEGMENTS - 1; i >= 0; i--) begin
      if (live[i]) begin
        first_seg = SIDX_W'(i);
      end
    end
  end

  assign starting = !active && item.start_req;
  assign go       = active || (starting && (cfg.loop_count != 8'd0) && first_ok);
  assign cur_seg  = starting ? first_seg : seg_idx;
  assign cur_loop = starting ? 8'd1 : loop_idx;
  assign loop_inc = {1'b0, cur_loop} + 9'd1;

  // First live segment after the current one in the same loop.
  always_comb begin
    later_ok  = 1'b0;
    later_seg = '0;
    for (int i = NUM_SEGMENTS - 1; i >= 0; i--) begin
      if (live[i] && (i > int'(cur_seg))) begin
        later_ok  = 1'b1;
        later_seg = SIDX_W'(i);
      end
    end
  end

  // The segment runs out on this tick when one tick is left.
  assign at_end = starting ?
                  ((seg_dur(cfg.segment_durations, 3'(first_seg)) == 16'd1) &&
                   (cfg.ticks_per_unit == 20'd1)) :
                  (ticks_left <= 36'd1);

  // One shared multiplier forms the tick count of the segment being loaded.
  assign mul_seg    = (at_end && later_ok) ? later_seg : first_seg;
  assign prod       = 36'(seg_dur(cfg.segment_durations, 3'(mul_seg))) *
                      36'(cfg.ticks_per_unit);
  assign base_ticks = starting ? prod : ticks_left;

  tphc_sense u_sense (
    .temp_first  (item.temp_first),
    .temp_second (item.temp_second),
    .setpoint    (seg_setpoint(cfg.setpoints, 3'(cur_seg))),
    .band        (cfg.band),
    .sense       (sense)
  );

  // Tick handling: start, stop, sensor check, relay and segment stepping.
  always_comb begin
    active_next = active;
    loop_next   = loop_idx;
    seg_next    = seg_idx;
    ticks_next  = ticks_left;
    relay_next  = relay;
    err_next    = last_error;
    tvalid      = 1'b0;
    end_run     = 1'b0;
    if (starting) begin
      err_next = ERR_NONE;
    end
    if (go) begin
      active_next = 1'b1;
      loop_next   = cur_loop;
      seg_next    = cur_seg;
      if (item.stop_request) begin
        end_run = 1'b1;
      end else if (item.sensor_fault) begin
        err_next = ERR_FAULT;
        end_run  = 1'b1;
      end else if (!sense.temp_ok) begin
        err_next = ERR_RANGE;
        end_run  = 1'b1;
      end else begin
        tvalid = 1'b1;
        if (sense.heat_on) begin
          relay_next = 1'b1;
        end else if (sense.heat_off) begin
          relay_next = 1'b0;
        end
        if (!at_end) begin
          ticks_next = base_ticks - 36'd1;
        end else if (later_ok) begin
          seg_next   = later_seg;
          ticks_next = prod;
        end else if (loop_inc > {1'b0, cfg.loop_count}) begin
          end_run = 1'b1;
        end else if (first_ok) begin
          seg_next   = first_seg;
          ticks_next = prod;
          loop_next  = loop_inc[7:0];
        end else begin
          end_run = 1'b1;
        end
      end
    end
    if (end_run) begin
      active_next = 1'b0;
      relay_next  = 1'b0;
      loop_next   = 8'd0;
      seg_next    = '0;
      ticks_next  = 36'd0;
    end
  end

  // State advances once per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      loop_idx   <= 8'd0;
      seg_idx    <= '0;
      ticks_left <= 36'd0;
      relay      <= 1'b0;
      last_error <= ERR_NONE;
    end else if (advance) begin
      active     <= active_next;
      loop_idx   <= loop_next;
      seg_idx    <= seg_next;
      ticks_left <= ticks_next;
      relay      <= relay_next;
      last_error <= err_next;
    end
  end

  // Result shows the state after the tick.
  always_comb begin
    result.relay_on        = relay_next;
    result.running         = active_next;
    result.loop_number     = loop_next;
    result.segment_number  = active_next ? (3'(seg_next) + 3'd1) : 3'd0;
    result.remaining_ticks = ticks_next;
    result.temp_valid      = tvalid;
    result.temperature     = tvalid ? sense.temp : 8'd0;
    result.error_code      = err_next;
  end

endmodule

@@ design/thermal_profile_hysteresis_controller.sv @@
// Top level of the heater profile controller with a hysteresis relay.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_ready    in_item   (one tick with sensor readings)
//   out       out_valid / out_ready  out_item  (state after the tick)
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (register write)
//
// One transaction per clock cycle is sustained while out_ready holds; a tick
// moves from the input register to the result register. All tick work runs in
// one pass of logic between the input register and the result register, one
// shared 16x20 multiplier included. Reset is synchronous and loads the register
// defaults. A stalled result holds in the result register while the next tick
// waits in the input register. The configuration port is always ready.
module thermal_profile_hysteresis_controller #(
  parameter int NUM_SEGMENTS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tphc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tphc_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import tphc_pkg::*;

  logic      in_vld;
  in_item_t  in_q;
  logic      advance;
  cfg_t      cfg;
  out_item_t result;
  logic      idle_clean;
  logic      run_live;
  logic      temp_clean;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoints         <= 32'd0;
      cfg.segment_durations <= 64'd0;
      cfg.loop_count        <= 8'd1;
      cfg.band              <= 8'd2;
      cfg.ticks_per_unit    <= 20'd36000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SETPOINTS:      cfg.setpoints         <= cfg_data[31:0];
        CFG_DURATIONS:      cfg.segment_durations <= cfg_data;
        CFG_LOOP_COUNT:     cfg.loop_count        <= cfg_data[7:0];
        CFG_BAND:           cfg.band              <= cfg_data[7:0];
        CFG_TICKS_PER_UNIT: cfg.ticks_per_unit    <= cfg_data[19:0];
        default:            ;
      endcase
    end
  end

  // A tick moves on when the result register is free or being emptied.
  assign advance  = in_vld && (!out_valid || out_ready);
  assign in_ready = !in_vld || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_item;
    end
  end

  tphc_core #(
    .NUM_SEGMENTS (NUM_SEGMENTS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_q),
    .cfg     (cfg),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  // Summary terms of the result that the checks below look at.
  assign idle_clean = (out_item.loop_number == 8'd0) && (out_item.segment_number == 3'd0) &&
                      (out_item.remaining_ticks == 36'd0) && !out_item.relay_on;
  assign run_live   = (out_item.remaining_ticks != 36'd0) &&
                      (out_item.segment_number != 3'd0) && (out_item.loop_number != 8'd0);
  assign temp_clean = (out_item.temperature <= TEMP_MAX) && (out_item.error_code == ERR_NONE);

  // Checks on the sequencer and the pipeline.
  `include "thermal_profile_hysteresis_controller_macros.svh"

  `TPHC_ASSERT_NOW(a_idle_zero, out_valid && !out_item.running, idle_clean, "idle result shows run state")
  `TPHC_ASSERT_NOW(a_run_live, out_valid && out_item.running, run_live, "running result without a live segment")
  `TPHC_ASSERT_NOW(a_temp_clean, out_valid && out_item.temp_valid, temp_clean, "accepted reading with an error")
  `TPHC_ASSERT_NEXT(a_pipe_moves, in_vld && out_ready, out_valid, "queued tick did not reach the result register")

endmodule
